FILE: rtl/bfdr_pkg.sv
`default_nettype none

package bfdr_pkg;

    // Default build of the delay store and the audio word.
    localparam int DELAY_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed register widths.
    localparam int DELAY_BITS     = 18;
    localparam int FRAC_BITS      = 8;
    localparam int COEF_BITS      = 17;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 18;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [COEF_BITS-1:0]      coef_t;
    typedef logic [DELAY_BITS-1:0]     delay_t;

    // Register map.
    localparam cfg_index_t REG_DELAY_LEFT  = 3'd0;
    localparam cfg_index_t REG_DELAY_RIGHT = 3'd1;
    localparam cfg_index_t REG_BLEND_LEFT  = 3'd2;
    localparam cfg_index_t REG_BLEND_RIGHT = 3'd3;
    localparam cfg_index_t REG_SMOOTHING   = 3'd4;

    localparam coef_t SMOOTHING_RESET = 17'd8579;
    localparam coef_t COEF_ONE        = 17'h10000;

    // A Q16 coefficient above one acts as exactly one.
    function automatic coef_t clamp_coef(input coef_t v);
        coef_t r;
        r = v[COEF_BITS-1] ? COEF_ONE : v;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/binaural_fractional_delay_render.sv
// Binaural fractional-delay renderer for one mono audio stream.
//
// Input channel (s_valid/s_ready/s_sample_in): one signed sample per beat. The sample is
// written into a circular delay store at the moment the beat is accepted.
// Result channel (m_valid/m_ready/m_left_out/m_right_out): one left/right pair per input
// beat, in input order. Each ear reads two taps that bracket its Q8 delay, interpolates
// them, runs the value through a one-pole low-pass, blends filtered and dry signal,
// halves, rounds and saturates.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; writes
// must only be issued while no sample is in flight. Unknown indexes are ignored.
// Timing: a result beat appears once the sequencer reaches its output step; a new input
// beat is not taken before that step. The four tap reads go one per cycle through the single
// read port of the delay store; the interpolate, filter, blend and round stages follow
// them, the two ears interleaved on one shared datapath.
// The next input beat is taken in the same cycle the finished pair is loaded into the
// output register. If the receiver stalls, the pair waits in that register and the block
// holds at its final step until the register is free.
// Reset: the write pointer, filter memories and settings return to their initial
// values. The store itself is not swept; a wrap flag and the write pointer mark which
// slots were written, and unwritten slots read as zero, so no clearing pass is needed.
`default_nettype none

module binaural_fractional_delay_render #(
    parameter int DELAY_DEPTH = bfdr_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = bfdr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]         s_sample_in,

    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [SAMPLE_BITS-1:0]              m_left_out,
    output logic signed [SAMPLE_BITS-1:0]              m_right_out,

    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [bfdr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [bfdr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    // Widths. The store index is AW bits; tap arithmetic is done in IW bits so that the
    // integer delay and the pointer both fit with room for a sign.
    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int DB  = bfdr_pkg::DELAY_BITS;
    localparam int FB  = bfdr_pkg::FRAC_BITS;
    localparam int WB  = DB - FB;
    localparam int IW  = ((AW > WB) ? AW : WB) + 2;
    localparam int XIW = SB + FB + 1;     // interpolated value, Q8
    localparam int XW  = XIW + 8;         // interpolated value, Q16
    localparam int MW  = SB + 16;         // filter memory, Q16
    localparam int EW  = SB + 17;         // filter error and blend difference
    localparam int PW  = EW + 17;         // products and mix accumulator

    localparam logic [31:0]   DELAY_MAX  = 32'((DELAY_DEPTH - 2) * 256);
    localparam logic [AW-1:0] DEPTH_LAST = AW'(DELAY_DEPTH - 1);
    localparam logic [IW-1:0] DEPTH_IW   = IW'(DELAY_DEPTH);

    // Sequencer steps. Reads: left newer, left older, right newer, right older.
    localparam logic [3:0] ST_LN  = 4'd0;
    localparam logic [3:0] ST_LO  = 4'd1;
    localparam logic [3:0] ST_RN  = 4'd2;
    localparam logic [3:0] ST_RO  = 4'd3;
    localparam logic [3:0] ST_IR  = 4'd4;
    localparam logic [3:0] ST_FR  = 4'd5;
    localparam logic [3:0] ST_UR  = 4'd6;
    localparam logic [3:0] ST_BR  = 4'd7;
    localparam logic [3:0] ST_OUT = 4'd8;

    // Configuration registers.
    bfdr_pkg::delay_t delay_left_reg;
    bfdr_pkg::delay_t delay_right_reg;
    bfdr_pkg::coef_t  blend_left_reg;
    bfdr_pkg::coef_t  blend_right_reg;
    bfdr_pkg::coef_t  smoothing_reg;

    // Control state.
    logic            busy_reg;
    logic [3:0]      step_reg;
    logic [AW-1:0]   wp_reg;
    logic            wrapped_reg;
    logic            m_valid_reg;

    // Delay store and its registered read port.
    logic signed [SB-1:0] delay_mem [DELAY_DEPTH];
    logic signed [SB-1:0] rd_data_reg;
    logic                 rd_zero_reg;

    // Datapath registers.
    logic signed [SB-1:0]  newer_reg;
    logic signed [XIW-1:0] xi_reg;
    logic signed [XW-1:0]  x1_reg;
    logic signed [XW-1:0]  x2_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [EW-1:0]  g_reg;
    logic signed [PW-1:0]  acc_reg;
    logic signed [MW-1:0]  filt_left_reg;
    logic signed [MW-1:0]  filt_right_reg;
    logic signed [SB-1:0]  left_res_reg;
    logic signed [SB-1:0]  left_out_reg;
    logic signed [SB-1:0]  right_out_reg;

    logic in_accept;
    logic out_load;

    assign cfg_ready   = 1'b1;
    assign out_load    = busy_reg && (step_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign s_ready     = !busy_reg || out_load;
    assign in_accept   = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_left_out  = left_out_reg;
    assign m_right_out = right_out_reg;

    // Delays are clamped so that both taps stay inside the store.
    logic [DB-1:0] dl_clamp;
    logic [DB-1:0] dr_clamp;

    assign dl_clamp = (32'(delay_left_reg) > DELAY_MAX) ? DELAY_MAX[DB-1:0] : delay_left_reg;
    assign dr_clamp = (32'(delay_right_reg) > DELAY_MAX) ? DELAY_MAX[DB-1:0] : delay_right_reg;

    // Tap address for the current read step.
    logic          rd_right;
    logic          rd_older;
    logic [DB-1:0] rd_delay;
    logic [IW-1:0] tap_diff;
    logic [IW-1:0] tap_wrap;
    logic [AW-1:0] newer_idx;
    logic [AW-1:0] older_idx;
    logic [AW-1:0] rd_addr;
    logic          rd_written;

    assign rd_right  = (step_reg == ST_RN) || (step_reg == ST_RO);
    assign rd_older  = (step_reg == ST_LO) || (step_reg == ST_RO);
    assign rd_delay  = rd_right ? dr_clamp : dl_clamp;
    assign tap_diff  = IW'(wp_reg) - IW'(rd_delay[DB-1:FB]);
    assign tap_wrap  = tap_diff[IW-1] ? (tap_diff + DEPTH_IW) : tap_diff;
    assign newer_idx = tap_wrap[AW-1:0];
    assign older_idx = (newer_idx == '0) ? DEPTH_LAST : (newer_idx - 1'b1);
    assign rd_addr   = rd_older ? older_idx : newer_idx;
    // Slots up to the write pointer, or all once the pointer has wrapped, hold samples.
    assign rd_written = wrapped_reg || (rd_addr <= wp_reg);

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            delay_mem[wp_reg] <= s_sample_in;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= delay_mem[rd_addr];
        rd_zero_reg <= !rd_written;
    end

    // Linear interpolation: newer*256 + (older - newer)*f.
    logic signed [SB-1:0]    rd_val;
    logic [FB-1:0]           interp_frac;
    logic signed [SB:0]      tap_delta;
    logic signed [FB:0]      frac_s;
    logic signed [SB+FB+1:0] interp_prod;
    logic signed [SB+FB+1:0] interp_sum;
    logic signed [XIW-1:0]   xi_next;

    assign rd_val      = rd_zero_reg ? '0 : rd_data_reg;
    assign interp_frac = (step_reg == ST_IR) ? dr_clamp[FB-1:0] : dl_clamp[FB-1:0];
    assign tap_delta   = (SB+1)'(rd_val) - (SB+1)'(newer_reg);
    assign frac_s      = $signed({1'b0, interp_frac});
    assign interp_prod = tap_delta * frac_s;
    assign interp_sum  = ((SB+FB+2)'(newer_reg) <<< FB) + interp_prod;
    assign xi_next     = interp_sum[XIW-1:0];

    // One-pole error times smoothing; a coefficient of one is a plain shift.
    logic signed [XW-1:0] x_cur;
    logic signed [MW-1:0] filt_mult;
    logic signed [EW-1:0] filt_err;
    bfdr_pkg::coef_t      k_coef;
    logic signed [PW-1:0] prod_next;

    assign x_cur     = {xi_reg, 8'b0};
    assign filt_mult = (step_reg == ST_FR) ? filt_right_reg : filt_left_reg;
    assign filt_err  = EW'(x_cur) - EW'(filt_mult);
    assign k_coef    = bfdr_pkg::clamp_coef(smoothing_reg);
    assign prod_next = k_coef[16] ? (PW'(filt_err) <<< 16)
                                  : PW'(filt_err) * $signed({1'b0, k_coef[15:0]});

    // Filter update with round half up, and the filtered-minus-dry difference.
    logic signed [MW-1:0] filt_upd;
    logic signed [PW-1:0] filt_rnd;
    logic signed [MW-1:0] m_next;
    logic signed [EW-1:0] g_next;

    assign filt_upd = (step_reg == ST_UR) ? filt_right_reg : filt_left_reg;
    assign filt_rnd = (prod_reg + PW'(32768)) >>> 16;
    assign m_next   = filt_upd + filt_rnd[MW-1:0];
    assign g_next   = EW'(m_next) - EW'(x1_reg);

    // Mix: x*65536 + (m - x)*blend, in Q32.
    bfdr_pkg::coef_t      b_coef;
    logic signed [PW-1:0] acc_next;

    assign b_coef   = bfdr_pkg::clamp_coef((step_reg == ST_BR) ? blend_right_reg
                                                               : blend_left_reg);
    assign acc_next = (PW'(x2_reg) <<< 16)
                    + (b_coef[16] ? (PW'(g_reg) <<< 16)
                                  : PW'(g_reg) * $signed({1'b0, b_coef[15:0]}));

    // Halve with round half up, then saturate.
    logic signed [PW-1:0] y_full;
    logic                 y_fits;
    logic signed [SB-1:0] y_sat;

    assign y_full = (acc_reg + (PW'(1) <<< 32)) >>> 33;
    assign y_fits = (&y_full[PW-1:SB-1]) || !(|y_full[PW-1:SB-1]);
    assign y_sat  = y_fits ? y_full[SB-1:0]
                           : (y_full[PW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_left_reg  <= '0;
            delay_right_reg <= '0;
            blend_left_reg  <= '0;
            blend_right_reg <= '0;
            smoothing_reg   <= bfdr_pkg::SMOOTHING_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bfdr_pkg::REG_DELAY_LEFT: begin
                    delay_left_reg <= cfg_data[DB-1:0];
                end
                bfdr_pkg::REG_DELAY_RIGHT: begin
                    delay_right_reg <= cfg_data[DB-1:0];
                end
                bfdr_pkg::REG_BLEND_LEFT: begin
                    blend_left_reg <= cfg_data[bfdr_pkg::COEF_BITS-1:0];
                end
                bfdr_pkg::REG_BLEND_RIGHT: begin
                    blend_right_reg <= cfg_data[bfdr_pkg::COEF_BITS-1:0];
                end
                bfdr_pkg::REG_SMOOTHING: begin
                    smoothing_reg <= cfg_data[bfdr_pkg::COEF_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer, write pointer, filter memories and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            step_reg       <= ST_LN;
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            filt_left_reg  <= '0;
            filt_right_reg <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (busy_reg && (step_reg != ST_OUT)) begin
                step_reg <= step_reg + 4'd1;
            end
            if (out_load) begin
                busy_reg <= 1'b0;
            end
            if (in_accept) begin
                busy_reg <= 1'b1;
                step_reg <= ST_LN;
            end

            if (busy_reg) begin
                case (step_reg)
                    ST_RO: begin
                        // Last tap address issued: the pointer may move on.
                        wp_reg <= (wp_reg == DEPTH_LAST) ? '0 : (wp_reg + 1'b1);
                        if (wp_reg == DEPTH_LAST) begin
                            wrapped_reg <= 1'b1;
                        end
                    end
                    ST_IR: begin
                        filt_left_reg <= m_next;
                    end
                    ST_UR: begin
                        filt_right_reg <= m_next;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers; the two ears run interleaved on the same stages.
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            case (step_reg)
                ST_LO: begin
                    newer_reg <= rd_val;
                end
                ST_RN: begin
                    xi_reg <= xi_next;
                end
                ST_RO: begin
                    newer_reg <= rd_val;
                    prod_reg  <= prod_next;
                    x1_reg    <= x_cur;
                end
                ST_IR: begin
                    xi_reg <= xi_next;
                    g_reg  <= g_next;
                    x2_reg <= x1_reg;
                end
                ST_FR: begin
                    prod_reg <= prod_next;
                    x1_reg   <= x_cur;
                    acc_reg  <= acc_next;
                end
                ST_UR: begin
                    g_reg        <= g_next;
                    x2_reg       <= x1_reg;
                    left_res_reg <= y_sat;
                end
                ST_BR: begin
                    acc_reg <= acc_next;
                end
                ST_OUT: begin
                    if (out_load) begin
                        left_out_reg  <= left_res_reg;
                        right_out_reg <= y_sat;
                    end
                end
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The sequencer walks its steps one per cycle until the output step.
    a_step_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (step_reg != ST_OUT)) |=> (busy_reg && (step_reg == $past(step_reg) + 4'd1)))
        else $error("sequencer step did not advance");

    // No new sample is taken while an earlier one is still being worked on.
    a_no_early_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (step_reg != ST_OUT)) |-> !s_ready)
        else $error("input accepted while an item is in flight");

    // The write pointer moves only after the last tap address of an item.
    a_wp_moves_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !(busy_reg && (step_reg == ST_RO)) |=> $stable(wp_reg))
        else $error("write pointer moved outside its step");

    // A result is only raised from the output step of an item.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(busy_reg && (step_reg == ST_OUT)))
        else $error("result valid raised outside the output step");
`endif

endmodule

`default_nettype wire

FILE: sim/ear_pair_predictor_pkg.sv
package ear_pair_predictor_pkg;

    import bfdr_pkg::*;

    localparam int STORE_DEPTH   = DELAY_DEPTH_DEF;
    localparam int MAX_TAP_DELAY = (STORE_DEPTH - 2) << FRAC_BITS;
    localparam longint SAMPLE_HI = (64'sd1 <<< (SAMPLE_BITS_DEF - 1)) - 1;
    localparam longint SAMPLE_LO = -(64'sd1 <<< (SAMPLE_BITS_DEF - 1));
    localparam longint Q16_ONE   = 64'sd65536;

    typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } ear_pair_t;

    // Predicts the left/right pair for every accepted sample and checks the
    // pairs that come back against them in order.
    class ear_pair_predictor;
        sample_t   store [STORE_DEPTH];
        int        wr_ptr;
        longint    lp_left;
        longint    lp_right;
        delay_t    delay_l;
        delay_t    delay_r;
        coef_t     blend_l;
        coef_t     blend_r;
        coef_t     smooth;
        ear_pair_t awaited_pairs [$];
        int        mismatches;

        function new();
            foreach (store[i]) store[i] = '0;
            wr_ptr     = 0;
            lp_left    = 0;
            lp_right   = 0;
            delay_l    = '0;
            delay_r    = '0;
            blend_l    = '0;
            blend_r    = '0;
            smooth     = SMOOTHING_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_DELAY_LEFT:  delay_l = data[DELAY_BITS-1:0];
                REG_DELAY_RIGHT: delay_r = data[DELAY_BITS-1:0];
                REG_BLEND_LEFT:  blend_l = data[COEF_BITS-1:0];
                REG_BLEND_RIGHT: blend_r = data[COEF_BITS-1:0];
                REG_SMOOTHING:   smooth  = data[COEF_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Two taps around the delay, linear blend, one-pole low-pass, dry/wet
        // mix, halve with rounding, saturate.
        function sample_t render_ear(delay_t dly, coef_t blend, inout longint lp);
            int     eff;
            int     whole;
            int     newer_at;
            int     older_at;
            longint frac;
            longint newer;
            longint older;
            longint x;
            longint k;
            longint b;
            longint acc;
            longint y;
            eff      = (int'(dly) > MAX_TAP_DELAY) ? MAX_TAP_DELAY : int'(dly);
            whole    = eff >> FRAC_BITS;
            frac     = eff & 255;
            newer_at = (wr_ptr + STORE_DEPTH - whole) % STORE_DEPTH;
            older_at = (wr_ptr + 2 * STORE_DEPTH - whole - 1) % STORE_DEPTH;
            newer    = store[newer_at];
            older    = store[older_at];
            x        = (newer * (256 - frac) + older * frac) * 256;
            k        = smooth;
            b        = blend;
            if (k > Q16_ONE) k = Q16_ONE;
            if (b > Q16_ONE) b = Q16_ONE;
            lp  = lp + (((x - lp) * k + 32768) >>> 16);
            acc = lp * b + x * (Q16_ONE - b);
            y   = (acc + 64'sd4294967296) >>> 33;
            if (y > SAMPLE_HI) y = SAMPLE_HI;
            if (y < SAMPLE_LO) y = SAMPLE_LO;
            return sample_t'(y);
        endfunction

        function void take_sample(sample_t s);
            ear_pair_t pair;
            store[wr_ptr] = s;
            pair.left  = render_ear(delay_l, blend_l, lp_left);
            pair.right = render_ear(delay_r, blend_r, lp_right);
            wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
            awaited_pairs.push_back(pair);
        endfunction

        function void check_pair(longint unsigned stamp, sample_t l, sample_t r);
            ear_pair_t want;
            if (awaited_pairs.size() == 0) begin
                mismatches++;
                $display("%0d ns: unexpected result beat, expected none, actual left %0d right %0d",
                         stamp, l, r);
                return;
            end
            want = awaited_pairs.pop_front();
            if (l !== want.left) begin
                mismatches++;
                $display("%0d ns: left_out mismatch, expected %0d, actual %0d",
                         stamp, want.left, l);
            end
            if (r !== want.right) begin
                mismatches++;
                $display("%0d ns: right_out mismatch, expected %0d, actual %0d",
                         stamp, want.right, r);
            end
        endfunction

        function int awaited();
            return awaited_pairs.size();
        endfunction
    endclass

endpackage

FILE: sim/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bfdr_pkg::*;
    import ear_pair_predictor_pkg::*;

    // Delay from a taken sample to its returned pair; it sizes the final wait.
    localparam int RESULT_LATENCY = 9;

    // Indexes above the last register are spare and must be ignored.
    localparam int SPARE_INDEX_LO = REG_SMOOTHING + 1;
    localparam int SPARE_INDEX_HI = (1 << CFG_INDEX_BITS) - 1;
    localparam int CFG_DATA_ALL   = (1 << CFG_DATA_BITS) - 1;
    localparam int DELAY_ALL      = (1 << DELAY_BITS) - 1;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    sample_t    s_sample_in = '0;
    logic       m_ready     = 1'b0;
    logic       cfg_valid   = 1'b0;
    cfg_index_t cfg_index   = REG_DELAY_LEFT;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    logic    s_ready;
    logic    m_valid;
    logic    cfg_ready;
    sample_t m_left_out;
    sample_t m_right_out;

    // While this is set neither the sender nor the receiver idles.
    logic steady_run = 1'b0;

    ear_pair_predictor renderer = new();

    // Corner values of the audio word: both rails, zero, the smallest steps
    // either side of zero and the two alternating bit patterns.
    sample_t corner_samples [11] = '{
        16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh7FFF,
        16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh5555, 16'shAAAA
    };

    binaural_fractional_delay_render dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver. Values read right after the edge are the ones the flops saw
    // at that edge, so a beat counts when valid and ready were both high.
    // Ready is redrawn every cycle, low about twelve times in a hundred outside the steady run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                renderer.check_pair($time, m_left_out, m_right_out);
            end
            m_ready <= steady_run || ($urandom_range(0, 99) >= 12);
        end
    end

    // Offers one sample and returns at the edge where it is taken. Valid is
    // only dropped when a gap is inserted, so back-to-back beats never see
    // valid lowered and raised in the same step.
    task automatic send_sample(input sample_t value);
        if (!steady_run && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= value;
        do @(posedge aclk); while (!s_ready);
        renderer.take_sample(value);
    endtask

    // Holds the sender back until every pair it is owed has come back. Each
    // sample yields exactly one pair, so the block is idle at that point.
    task automatic drain();
        s_valid <= 1'b0;
        while (renderer.awaited() != 0) @(posedge aclk);
    endtask

    // One register beat; the caller drops cfg_valid after the last one.
    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        do @(posedge aclk); while (!cfg_ready);
        renderer.write_reg(idx, value[CFG_DATA_BITS-1:0]);
    endtask

    // Rewrites every register once the block is idle. A spare index with
    // random data goes first and must leave the settings untouched.
    task automatic configure(input int unsigned dly_l, input int unsigned dly_r,
                             input int unsigned bl_l, input int unsigned bl_r,
                             input int unsigned smooth);
        drain();
        write_reg(cfg_index_t'($urandom_range(SPARE_INDEX_LO, SPARE_INDEX_HI)),
                  $urandom_range(0, CFG_DATA_ALL));
        write_reg(REG_DELAY_LEFT, dly_l);
        write_reg(REG_DELAY_RIGHT, dly_r);
        write_reg(REG_BLEND_LEFT, bl_l);
        write_reg(REG_BLEND_RIGHT, bl_r);
        write_reg(REG_SMOOTHING, smooth);
        cfg_valid <= 1'b0;
    endtask

    // Delays favor the range that reaches samples already written, with the
    // clamp boundary and the full field width mixed in.
    function automatic int unsigned pick_delay();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return MAX_TAP_DELAY;
            2: return MAX_TAP_DELAY + 1;
            3: return DELAY_ALL;
            4: return $urandom_range(0, 255);
            5, 6, 7: return $urandom_range(0, 300 << FRAC_BITS);
            default: return $urandom_range(0, DELAY_ALL);
        endcase
    endfunction

    // Coefficients around one, including data with the unused top bit set.
    function automatic int unsigned pick_coef();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return COEF_ONE;
            2: return COEF_ONE - 1;
            3: return COEF_ONE + 1;
            4: return CFG_DATA_ALL;
            5: return $urandom_range(0, CFG_DATA_ALL);
            default: return $urandom_range(0, COEF_ONE);
        endcase
    endfunction

    function automatic sample_t pick_sample();
        if ($urandom_range(0, 99) < 15) begin
            return corner_samples[$urandom_range(0, 10)];
        end
        return sample_t'($urandom_range(0, 16'hFFFF));
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: zero delay, dry output, default smoothing. The
        // first beats also read slots that were never written.
        foreach (corner_samples[i]) send_sample(corner_samples[i]);

        // Fractional left tap, right delay beyond the store, fully filtered
        // left ear, right blend above one, filter bypassed.
        configure(384, DELAY_ALL, COEF_ONE, CFG_DATA_ALL >> 1, COEF_ONE);
        for (int n = 0; n < 6; n++) send_sample(corner_samples[n]);

        // Largest fraction, the exact clamp value, smoothing of zero so the
        // filter memory holds while the input moves.
        configure(255, MAX_TAP_DELAY, COEF_ONE - 1, 1, 0);
        for (int n = 5; n < 10; n++) send_sample(corner_samples[n]);

        // Smoothing above one, delay just past the clamp.
        configure(MAX_TAP_DELAY + 1, 0, 0, COEF_ONE, CFG_DATA_ALL);
        for (int n = 8; n < 11; n++) send_sample(corner_samples[n]);

        // Random part: nine settings of fifty beats each. The second one runs
        // with no idling on either side, and the sixth stops halfway until
        // every pair has come back.
        for (int phase = 0; phase < 9; phase++) begin
            configure(pick_delay(), pick_delay(), pick_coef(), pick_coef(), pick_coef());
            steady_run <= (phase == 1);
            for (int n = 0; n < 50; n++) begin
                if (phase == 5 && n == 25) begin
                    drain();
                end
                send_sample(pick_sample());
            end
        end

        drain();
        steady_run <= 1'b0;
        repeat (4 * RESULT_LATENCY) @(posedge aclk);

        if (renderer.mismatches == 0 && renderer.awaited() == 0) begin
            $display("** binaural_fractional_delay_render: PASSED **");
        end else begin
            $display("** binaural_fractional_delay_render: FAILED **");
        end
        $finish;
    end

    // The whole run needs well under 100 us; anything near this bound means
    // a beat was never taken or a pair never came back.
    initial begin
        #2_000_000;
        $display("** binaural_fractional_delay_render: FAILED **");
        $finish;
    end

endmodule
